FILE: hw/rtl/hrwl_pkg.sv
`timescale 1ns / 1ps

package hrwl_pkg;

    localparam int DEF_ROW_WORDS = 16;
    localparam int ADDR_W        = 16;
    localparam int WORD_W        = 16;

    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    // 'A' - 10
    localparam logic [7:0] ALPHA_OFFSET = 8'd55;
    localparam logic [7:0] REC_EOF      = 8'h01;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef enum logic [8:0] {
        PH_WAIT  = 9'b000000001,
        PH_COUNT = 9'b000000010,
        PH_ADDR  = 9'b000000100,
        PH_TYPE  = 9'b000001000,
        PH_D0    = 9'b000010000,
        PH_D1    = 9'b000100000,
        PH_D2    = 9'b001000000,
        PH_D3    = 9'b010000000,
        PH_CSUM  = 9'b100000000
    } phase_t;

    // New base address; the row position is worked out from it
    typedef struct packed {
        logic                load;
        logic [ADDR_W-1:0]   value;
    } row_seed_t;

    // Base address advanced by one; wrap when it rolls over to zero
    typedef struct packed {
        logic step;
        logic wrap;
    } row_step_t;

    // No hex check: anything above '9' is taken as a letter digit
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_NINE)
        begin
            v = c - CH_ZERO;
        end
        else
        begin
            v = c - ALPHA_OFFSET;
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/hrwl_row_pos.sv
`timescale 1ns / 1ps

module hrwl_row_pos
    import hrwl_pkg::*;
#(
    parameter int ROW_WORDS = DEF_ROW_WORDS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  row_seed_t seed,
    input  row_step_t stp,
    output logic      row_end,
    output logic      busy
);

    localparam int PW        = (ROW_WORDS > 2) ? $clog2(ROW_WORDS) : 1;
    localparam int ROW_SHIFT = ADDR_W + $clog2(ROW_WORDS);
    localparam int QW        = ADDR_W + 17;
    // ceil(2^ROW_SHIFT / ROW_WORDS): exact quotient for any 16-bit address
    localparam logic [16:0] ROW_RECIP =
        17'(((2 ** ROW_SHIFT) + ROW_WORDS - 1) / ROW_WORDS);
    localparam logic [PW-1:0]     POS_LAST = PW'(ROW_WORDS - 1);
    localparam logic [ADDR_W:0]   ROW_LEN  = (ADDR_W + 1)'(ROW_WORDS);

    logic                seed_pend_reg;
    logic                quot_pend_reg;
    logic [ADDR_W-1:0]   seed_val_reg;
    logic [ADDR_W-1:0]   quot_reg;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [QW-1:0]       prod;
    logic [ADDR_W:0]     rem_full;
    logic [ADDR_W:0]     rem_fix;

    assign prod     = {17'b0, seed_val_reg} * {{ADDR_W{1'b0}}, ROW_RECIP};
    assign rem_full = {1'b0, seed_val_reg} - (ADDR_W + 1)'({1'b0, quot_reg} * ROW_LEN);
    assign rem_fix  = (rem_full >= ROW_LEN) ? (rem_full - ROW_LEN) : rem_full;

    always_comb
    begin
        pos_next = pos_reg;
        if (quot_pend_reg)
        begin
            pos_next = rem_fix[PW-1:0];
        end
        else if (stp.step)
        begin
            if (stp.wrap || pos_reg == POS_LAST)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_pend_reg <= 1'b0;
            quot_pend_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            seed_pend_reg <= seed.load;
            quot_pend_reg <= seed_pend_reg;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed.load)
        begin
            seed_val_reg <= seed.value;
        end
        if (seed_pend_reg)
        begin
            quot_reg <= ADDR_W'(prod >> ROW_SHIFT);
        end
    end

    assign row_end = (pos_reg == POS_LAST);
    assign busy    = seed_pend_reg | quot_pend_reg;

endmodule

FILE: hw/rtl/hex_record_word_loader.sv
`timescale 1ns / 1ps
// A character accepted into the decode register has its word or end-of-file result registered
// on the result port when it leaves that register; it waits there while a result is untaken.
// Throughput: one character per cycle; while a result waits to be taken one more beat
// can enter the decode register, then the input stalls until the result is taken.
// Reset (rst_n, async, active low): hunting for a colon, base address unset.

module hex_record_word_loader
    import hrwl_pkg::*;
#(
    parameter int ROW_WORDS = DEF_ROW_WORDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  logic [7:0]        char_in,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              kind,
    output logic [WORD_W-1:0] word_value,
    output logic [ADDR_W-1:0] word_address,
    output logic              row_last
);

    logic              s1_valid_reg;
    logic [7:0]        s1_char_reg;
    logic              s1_adv;

    phase_t            phase_reg,   phase_next;
    logic [7:0]        cnt_reg,     cnt_next;
    logic [7:0]        bytes_reg,   bytes_next;
    logic [ADDR_W-1:0] rec_addr_reg, rec_addr_next;
    logic [7:0]        rec_kind_reg, rec_kind_next;
    logic [WORD_W-1:0] accum_reg,   accum_next;
    logic [ADDR_W-1:0] base_reg,    base_next;

    logic              res_valid_reg;
    logic              res_kind_reg;
    logic [WORD_W-1:0] res_value_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              res_last_reg;

    logic              emit;
    logic              emit_kind;
    logic [WORD_W-1:0] emit_value;
    logic [ADDR_W-1:0] emit_addr;
    logic              emit_last;

    logic [7:0]        d;
    logic [ADDR_W-1:0] addr_shift;
    logic [ADDR_W-1:0] addr_word;
    logic [7:0]        kind_sum;
    logic [7:0]        cnt_inc;
    logic [WORD_W-1:0] word_done;

    row_seed_t         seed;
    row_step_t         stp;
    logic              row_end;
    logic              row_busy;

    assign s1_adv     = s1_valid_reg && (!res_valid_reg || result_ready);
    assign char_ready = !s1_valid_reg || s1_adv;

    assign d          = digit_value(s1_char_reg);
    assign cnt_inc    = cnt_reg + 8'd1;
    assign addr_shift = {rec_addr_reg[ADDR_W-5:0], 4'b0} + {8'b0, d};
    assign addr_word  = addr_shift >> 1;
    assign kind_sum   = {rec_kind_reg[3:0], 4'b0} + d;
    assign word_done  = accum_reg + {d, 8'b0};

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        bytes_next    = bytes_reg;
        rec_addr_next = rec_addr_reg;
        rec_kind_next = rec_kind_reg;
        accum_next    = accum_reg;
        base_next     = base_reg;
        emit          = 1'b0;
        emit_kind     = KIND_DATA;
        emit_value    = '0;
        emit_addr     = '0;
        emit_last     = 1'b0;
        seed          = '0;
        stp           = '0;
        case (phase_reg)
            PH_COUNT:
            begin
                bytes_next = {bytes_reg[3:0], 4'b0} + d;
                if (cnt_reg != 8'd0)
                begin
                    phase_next    = PH_ADDR;
                    cnt_next      = '0;
                    rec_addr_next = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_ADDR:
            begin
                if (cnt_reg > 8'd2)
                begin
                    cnt_next      = '0;
                    rec_addr_next = addr_word;
                    if (addr_word == '0)
                    begin
                        // record at address zero is dropped
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                        if (base_reg == '0)
                        begin
                            base_next  = addr_word;
                            seed.load  = 1'b1;
                            seed.value = addr_word;
                        end
                    end
                end
                else
                begin
                    cnt_next      = cnt_inc;
                    rec_addr_next = addr_shift;
                end
            end
            PH_TYPE:
            begin
                rec_kind_next = kind_sum;
                if (cnt_reg != 8'd0)
                begin
                    if (kind_sum == REC_EOF)
                    begin
                        phase_next = PH_WAIT;
                        cnt_next   = cnt_inc;
                        emit       = 1'b1;
                        emit_kind  = KIND_EOF;
                    end
                    else
                    begin
                        phase_next = PH_D0;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_D0:
            begin
                accum_next = {4'b0, d, 4'b0};
                phase_next = PH_D1;
            end
            PH_D1:
            begin
                accum_next = accum_reg + {8'b0, d};
                phase_next = PH_D2;
            end
            PH_D2:
            begin
                accum_next = accum_reg + {d[3:0], 12'b0};
                phase_next = PH_D3;
            end
            PH_D3:
            begin
                accum_next = word_done;
                emit       = 1'b1;
                emit_kind  = KIND_DATA;
                emit_value = word_done;
                emit_addr  = base_reg;
                emit_last  = row_end;
                base_next  = base_reg + 1'b1;
                stp.step   = 1'b1;
                stp.wrap   = (base_reg == {ADDR_W{1'b1}});
                if (cnt_inc < {1'b0, bytes_reg[7:1]})
                begin
                    phase_next = PH_D0;
                    cnt_next   = cnt_inc;
                end
                else
                begin
                    phase_next = PH_CSUM;
                    cnt_next   = '0;
                end
            end
            PH_CSUM:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg != 8'd0)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                if (s1_char_reg == CH_COLON)
                begin
                    phase_next = PH_COUNT;
                    cnt_next   = '0;
                    bytes_next = '0;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
        endcase
        if (!s1_adv)
        begin
            seed = '0;
            stp  = '0;
        end
    end

    hrwl_row_pos #(
        .ROW_WORDS (ROW_WORDS)
    ) u_row_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed    (seed),
        .stp     (stp),
        .row_end (row_end),
        .busy    (row_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            cnt_reg       <= '0;
            bytes_reg     <= '0;
            rec_addr_reg  <= '0;
            rec_kind_reg  <= '0;
            accum_reg     <= '0;
            base_reg      <= '0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                res_valid_reg <= emit;
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                bytes_reg     <= bytes_next;
                rec_addr_reg  <= rec_addr_next;
                rec_kind_reg  <= rec_kind_next;
                accum_reg     <= accum_next;
                base_reg      <= base_next;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            s1_char_reg <= char_in;
        end
        if (s1_adv)
        begin
            res_kind_reg  <= emit_kind;
            res_value_reg <= emit_value;
            res_addr_reg  <= emit_addr;
            res_last_reg  <= emit_last;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign word_value   = res_value_reg;
    assign word_address = res_addr_reg;
    assign row_last     = res_last_reg;

    // end-of-file beats carry no word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_EOF |->
            word_value == '0 && word_address == '0 && !row_last)
        else $error("end-of-file result carries word data");

    // row position must be settled before a word of the record goes out
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && phase_reg == PH_D3 |-> !row_busy)
        else $error("row position still being computed at word emission");

    // input stalls only when both the decode and result registers are full
    assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> s1_valid_reg && res_valid_reg && !result_ready)
        else $error("input stalled with room downstream");

    // a data record is only entered with a nonzero record address
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && phase_reg == PH_D0 |=> $past(rec_addr_reg) != '0)
        else $error("data record entered with zero address");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import hrwl_pkg::*;

    localparam int ROW          = DEF_ROW_WORDS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CHARS = 580;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_WORD = 8;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] value;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } loaded_word_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              char_valid   = 1'b0;
    logic              char_ready;
    logic [7:0]        char_in      = 8'h00;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              kind;
    logic [WORD_W-1:0] word_value;
    logic [ADDR_W-1:0] word_address;
    logic              row_last;

    logic [7:0]   pending_chars[$];
    loaded_word_t expected_words[$];
    loaded_word_t want;
    int           queued_chars = 0;
    int           mismatches   = 0;
    int           cycles       = 0;
    int           send_gap     = 0;
    int           stall_left   = 0;
    int           words_taken  = 0;
    bit           long_hold_done = 1'b0;

    // parser mirror
    phase_t      hx_phase  = PH_WAIT;
    logic [7:0]  hx_digits = 8'h00;
    logic [7:0]  hx_count  = 8'h00;
    logic [7:0]  hx_type   = 8'h00;
    logic [15:0] hx_addr   = 16'h0000;
    logic [15:0] hx_acc    = 16'h0000;
    logic [15:0] hx_base   = 16'h0000;

    hex_record_word_loader dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_in      (char_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .word_value   (word_value),
        .word_address (word_address),
        .row_last     (row_last)
    );

    always #6 clk = ~clk;

    function automatic void decode_char(input logic [7:0] c);
        logic [7:0]   d;
        logic [15:0]  dw;
        loaded_word_t w;
        d  = (c <= CH_NINE) ? c - CH_ZERO : c - ALPHA_OFFSET;
        dw = {8'h00, d};
        w  = '0;
        case (hx_phase)
            PH_COUNT:
            begin
                hx_count = {hx_count[3:0], 4'h0} + d;
                if (hx_digits > 0)
                begin
                    hx_phase  = PH_ADDR;
                    hx_digits = 8'h00;
                    hx_addr   = 16'h0000;
                end
                else
                    hx_digits = hx_digits + 8'd1;
            end
            PH_ADDR:
            begin
                hx_addr = {hx_addr[11:0], 4'h0} + dw;
                if (hx_digits > 2)
                begin
                    hx_digits = 8'h00;
                    hx_addr   = hx_addr >> 1;
                    if (hx_addr == 16'h0000)
                        hx_phase = PH_WAIT;
                    else
                    begin
                        hx_phase = PH_TYPE;
                        if (hx_base == 16'h0000)
                            hx_base = hx_addr;
                    end
                end
                else
                    hx_digits = hx_digits + 8'd1;
            end
            PH_TYPE:
            begin
                hx_type = {hx_type[3:0], 4'h0} + d;
                if (hx_digits > 0)
                begin
                    hx_digits = hx_digits + 8'd1;
                    if (hx_type == REC_EOF)
                    begin
                        hx_phase = PH_WAIT;
                        w.kind   = KIND_EOF;
                        expected_words.push_back(w);
                    end
                    else
                    begin
                        hx_phase  = PH_D0;
                        hx_digits = 8'h00;
                    end
                end
                else
                    hx_digits = hx_digits + 8'd1;
            end
            PH_D0:
            begin
                hx_acc   = dw << 4;
                hx_phase = PH_D1;
            end
            PH_D1:
            begin
                hx_acc   = hx_acc + dw;
                hx_phase = PH_D2;
            end
            PH_D2:
            begin
                hx_acc   = hx_acc + (dw << 12);
                hx_phase = PH_D3;
            end
            PH_D3:
            begin
                hx_acc    = hx_acc + (dw << 8);
                hx_digits = hx_digits + 8'd1;
                w.kind    = KIND_DATA;
                w.value   = hx_acc;
                w.addr    = hx_base;
                w.last    = (hx_base % ROW) == ROW - 1;
                expected_words.push_back(w);
                hx_base   = hx_base + 16'd1;
                if (hx_digits < (hx_count >> 1))
                    hx_phase = PH_D0;
                else
                begin
                    hx_phase  = PH_CSUM;
                    hx_digits = 8'h00;
                end
            end
            PH_CSUM:
            begin
                if (hx_digits > 0)
                    hx_phase = PH_WAIT;
                hx_digits = hx_digits + 8'd1;
            end
            default:
            begin
                if (c == CH_COLON)
                begin
                    hx_phase  = PH_COUNT;
                    hx_digits = 8'h00;
                    hx_count  = 8'h00;
                end
                else
                    hx_phase = PH_WAIT;
            end
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return {4'h0, n} + ((n < 4'd10) ? CH_ZERO : ALPHA_OFFSET);
    endfunction

    // mostly clean hex, now and then lowercase or an arbitrary byte
    function automatic logic [7:0] data_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 94)
            return hex_char(4'($urandom_range(0, 15)));
        if (r < 97)
            return 8'h61 + 8'($urandom_range(0, 5));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    task automatic push_char(input logic [7:0] c);
        pending_chars.push_back(c);
        queued_chars++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_char(hex_char(b[7:4]));
        push_char(hex_char(b[3:0]));
    endtask

    task automatic push_header(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype);
        push_char(CH_COLON);
        push_byte(count);
        push_byte(addr[15:8]);
        push_byte(addr[7:0]);
        push_byte(rtype);
    endtask

    task automatic push_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype);
        int n;
        push_header(count, addr, rtype);
        if (rtype != REC_EOF && addr[15:1] != 15'h0000)
        begin
            n = ((count >> 1) == 0) ? 1 : (count >> 1);
            repeat (n * 4) push_char(data_char());
        end
        push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1))
        begin
            push_char(8'h0D);
            push_char(8'h0A);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_chars.size() != 0 || char_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender: one beat per char, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in    <= 8'h00;
            send_gap   <= 0;
        end
        else
        begin
            if (char_valid && char_ready)
                decode_char(char_in);
            if (!char_valid || char_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap   <= send_gap - 1;
                    char_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    char_in    <= pending_chars.pop_front();
                    char_valid <= 1'b1;
                    send_gap   <= idle_len();
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each result beat, random stalls, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready   <= 1'b0;
            stall_left     <= 0;
            words_taken    <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                words_taken <= words_taken + 1;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result: kind %0d value %h address %h",
                           kind, word_value, word_address);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("word_value", want.value, word_value);
                    check_field("word_address", want.addr, word_address);
                    check_field("row_last", 16'(want.last), 16'(row_last));
                end
            end
            if (!long_hold_done && words_taken == HOLD_AT_WORD)
            begin
                long_hold_done <= 1'b1;
                stall_left     <= LONG_HOLD;
                result_ready   <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left   <= idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int         start;
        int         pick;
        bit         paused;
        logic [7:0] cnt;
        logic [15:0] adr;
        logic [7:0] typ;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // noise while hunting for a colon
        push_char(8'h00);
        push_char(8'hFF);
        // word address zero: record dropped after the address digits
        push_char(CH_COLON);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'h01);
        // seeds base at 0x7FFF, odd count gives one word, unusual type is data
        push_header(8'h01, 16'hFFFE, 8'h05);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_header(8'h00, 16'h0002, REC_EOF);
        wait_drained();

        start  = queued_chars;
        paused = 1'b0;
        while (queued_chars - start < RANDOM_CHARS)
        begin
            if (!paused && queued_chars - start >= RANDOM_CHARS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    cnt = 8'(2 * $urandom_range(0, 8));
                else if (pick < 85)
                    cnt = 8'($urandom_range(0, 17));
                else
                    cnt = 8'(2 * $urandom_range(9, 40));
                adr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                  : 16'($urandom_range(2, 16'hFFFF));
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    typ = 8'h00;
                else if (pick < 85)
                    typ = REC_EOF;
                else
                    typ = 8'($urandom_range(0, 255));
                push_record(cnt, adr, typ);
            end
            else if (pick < 87)
            begin
                repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken record: arbitrary bytes after the colon
                push_char(CH_COLON);
                repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
            end
        end
        wait_drained();

        // get back to hunting for a colon before the closing records
        while (hx_phase != PH_WAIT)
        begin
            push_char(CH_ZERO);
            wait_drained();
        end

        // one data record, then end of file
        push_record(8'h04, 16'h2468, 8'h00);
        push_header(8'h00, 16'h0010, REC_EOF);
        wait_drained();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hrwl_pkg.sv
hw/rtl/hrwl_row_pos.sv
hw/rtl/hex_record_word_loader.sv
verif/tb.sv
